>>> rtl/mkey_pkg.sv
package mkey_pkg;

  // field and register widths
  localparam int CHAR_W       = 8;
  localparam int UNIT_TICKS_W = 20;
  localparam int DASH_W       = 4;
  localparam int UNITS_W      = 5;
  localparam int DUR_W        = 25;
  localparam int CODE_LEN     = 6;
  localparam int LEN_W        = 3;
  localparam int CFG_IDX_W    = 2;

  // queue depth between classifier and sequencer
  localparam int FIFO_DEPTH = 2;

  // fixed lengths in units
  localparam logic [UNITS_W-1:0] SPACE_UNITS   = 5'd7;
  localparam logic [UNITS_W-1:0] ERROR_UNITS   = 5'd20;
  localparam logic [UNITS_W-1:0] CHARGAP_UNITS = 5'd30;
  localparam logic [UNITS_W-1:0] ONE_UNIT      = 5'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_UNITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_ENABLE = 2'd2;

  // register reset values
  localparam logic [UNIT_TICKS_W-1:0] RST_UNIT_TICKS = 20'd100000;
  localparam logic [DASH_W-1:0]       RST_DASH_UNITS = 4'd5;
  localparam logic                    RST_GAP_ENABLE = 1'b1;

  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_SPACE = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_CODE  = 2'd2
  } kind_e;

  // classified character: pattern is left aligned, first element in the msb,
  // a set bit is a dash
  typedef struct packed {
    kind_e               kind;
    logic [LEN_W-1:0]    len;
    logic [CODE_LEN-1:0] pat;
  } entry_t;

  typedef struct packed {
    logic [UNIT_TICKS_W-1:0] unit_ticks;
    logic [DASH_W-1:0]       dash_units;
    logic                    gap_enable;
  } cfg_t;

  function automatic entry_t classify(input logic [CHAR_W-1:0] ch);
    entry_t e;
    e.kind = KIND_CODE;
    e.len  = '0;
    e.pat  = '0;
    case (ch)
      "A": begin e.len = 3'd2; e.pat = 6'b010000; end
      "B": begin e.len = 3'd4; e.pat = 6'b100000; end
      "C": begin e.len = 3'd4; e.pat = 6'b101000; end
      "D": begin e.len = 3'd3; e.pat = 6'b100000; end
      "E": begin e.len = 3'd1; e.pat = 6'b000000; end
      "F": begin e.len = 3'd4; e.pat = 6'b001000; end
      "G": begin e.len = 3'd3; e.pat = 6'b110000; end
      "H": begin e.len = 3'd4; e.pat = 6'b000000; end
      "I": begin e.len = 3'd2; e.pat = 6'b000000; end
      "J": begin e.len = 3'd4; e.pat = 6'b011100; end
      "K": begin e.len = 3'd3; e.pat = 6'b101000; end
      "L": begin e.len = 3'd4; e.pat = 6'b010000; end
      "M": begin e.len = 3'd2; e.pat = 6'b110000; end
      "N": begin e.len = 3'd2; e.pat = 6'b100000; end
      "O": begin e.len = 3'd3; e.pat = 6'b111000; end
      "P": begin e.len = 3'd4; e.pat = 6'b011000; end
      "Q": begin e.len = 3'd4; e.pat = 6'b110100; end
      "R": begin e.len = 3'd3; e.pat = 6'b010000; end
      "S": begin e.len = 3'd3; e.pat = 6'b000000; end
      "T": begin e.len = 3'd1; e.pat = 6'b100000; end
      "U": begin e.len = 3'd3; e.pat = 6'b001000; end
      "V": begin e.len = 3'd4; e.pat = 6'b000100; end
      "W": begin e.len = 3'd3; e.pat = 6'b011000; end
      "X": begin e.len = 3'd4; e.pat = 6'b100100; end
      "Y": begin e.len = 3'd4; e.pat = 6'b101100; end
      "Z": begin e.len = 3'd4; e.pat = 6'b110000; end
      "0": begin e.len = 3'd5; e.pat = 6'b111110; end
      "1": begin e.len = 3'd5; e.pat = 6'b011110; end
      "2": begin e.len = 3'd5; e.pat = 6'b001110; end
      "3": begin e.len = 3'd5; e.pat = 6'b000110; end
      "4": begin e.len = 3'd5; e.pat = 6'b000010; end
      "5": begin e.len = 3'd5; e.pat = 6'b000000; end
      "6": begin e.len = 3'd5; e.pat = 6'b100000; end
      "7": begin e.len = 3'd5; e.pat = 6'b110000; end
      "8": begin e.len = 3'd5; e.pat = 6'b111000; end
      "9": begin e.len = 3'd5; e.pat = 6'b111100; end
      ".": begin e.len = 3'd6; e.pat = 6'b010101; end
      ",": begin e.len = 3'd6; e.pat = 6'b110011; end
      "?": begin e.len = 3'd6; e.pat = 6'b001100; end
      ":": begin e.len = 3'd6; e.pat = 6'b111000; end
      " ": begin e.kind = KIND_SPACE; end
      default: begin e.kind = KIND_ERROR; end
    endcase
    return e;
  endfunction

endpackage

>>> rtl/mkey_front.sv
module mkey_front (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [mkey_pkg::CHAR_W-1:0] character_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output mkey_pkg::entry_t         q_entry_o
);
  import mkey_pkg::*;

  // stall only while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // table lookup of the incoming character
  assign q_entry_o = classify(character_i);

endmodule

>>> rtl/mkey_fifo.sv
module mkey_fifo #(
  parameter int Depth = mkey_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mkey_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output mkey_pkg::entry_t entry_o,
  output logic             empty_o
);
  import mkey_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/mkey_back.sv
module mkey_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mkey_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  mkey_pkg::entry_t              q_entry_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          key_down_o,
  output logic [mkey_pkg::DUR_W-1:0]    duration_ticks_o,
  output logic                          last_o
);
  import mkey_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SPACE = 7'b0000010,
    ST_ERROR = 7'b0000100,
    ST_TONE  = 7'b0001000,
    ST_EGAP  = 7'b0010000,
    ST_END   = 7'b0100000,
    ST_CGAP  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CODE_LEN-1:0] pat_q, pat_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  logic                key_q, key_d, last_q, last_d;
  logic [DUR_W-1:0]    dur_q, dur_d;
  logic                slot_free, emit, key, last;
  logic [UNITS_W-1:0]  units;
  logic [UNITS_W-1:0]  dash_u;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign dash_u    = UNITS_W'(cfg_i.dash_units);

  // sequencer: one result per cycle once a character is loaded, while the output is not stalled
  always_comb begin
    state_d = state_q;
    pat_d   = pat_q;
    rem_d   = rem_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    key     = 1'b0;
    last    = 1'b0;
    units   = ONE_UNIT;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          pat_d   = q_entry_i.pat;
          rem_d   = q_entry_i.len;
          case (q_entry_i.kind)
            KIND_SPACE: state_d = ST_SPACE;
            KIND_CODE:  state_d = ST_TONE;
            default:    state_d = ST_ERROR;
          endcase
        end
      end
      ST_SPACE: begin
        emit  = slot_free;
        units = SPACE_UNITS;
        last  = !cfg_i.gap_enable;
        if (slot_free) begin
          state_d = cfg_i.gap_enable ? ST_CGAP : ST_IDLE;
        end
      end
      ST_ERROR: begin
        emit  = slot_free;
        key   = 1'b1;
        units = ERROR_UNITS;
        last  = !cfg_i.gap_enable;
        if (slot_free) begin
          state_d = cfg_i.gap_enable ? ST_CGAP : ST_IDLE;
        end
      end
      ST_TONE: begin
        emit  = slot_free;
        key   = 1'b1;
        units = pat_q[CODE_LEN-1] ? dash_u : ONE_UNIT;
        if (slot_free) begin
          pat_d   = {pat_q[CODE_LEN-2:0], 1'b0};
          state_d = ST_EGAP;
        end
      end
      ST_EGAP: begin
        emit = slot_free;
        if (slot_free) begin
          rem_d   = rem_q - 1'b1;
          state_d = (rem_q == LEN_W'(1)) ? ST_END : ST_TONE;
        end
      end
      ST_END: begin
        emit  = slot_free;
        units = dash_u;
        last  = !cfg_i.gap_enable;
        if (slot_free) begin
          state_d = cfg_i.gap_enable ? ST_CGAP : ST_IDLE;
        end
      end
      ST_CGAP: begin
        emit  = slot_free;
        units = CHARGAP_UNITS;
        last  = 1'b1;
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register, duration scaled by the unit length
  always_comb begin
    out_valid_d = out_valid_q;
    key_d       = key_q;
    last_d      = last_q;
    dur_d       = dur_q;
    if (emit) begin
      out_valid_d = 1'b1;
      key_d       = key;
      last_d      = last;
      dur_d       = DUR_W'(units) * DUR_W'(cfg_i.unit_ticks);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    key_q  <= key_d;
    last_q <= last_d;
    dur_q  <= dur_d;
  end

  assign out_valid_o      = out_valid_q;
  assign key_down_o       = key_q;
  assign duration_ticks_o = dur_q;
  assign last_o           = last_q;

endmodule

>>> rtl/morse_character_keyer.sv
// Morse character keyer
//
// Input channel: in_valid_i / in_stall_o with character_i, one ASCII code per
// transaction. Output channel: out_valid_o / out_stall_i carrying key_down_o,
// duration_ticks_o and last_o; each transaction is one tone or silence, and
// last_o marks the final one of a character (1 to 14 per character).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 unit_ticks, 1 dash_units, 2 char_gap_enable); other indexes are ignored.
// Write only while the block is idle.
//
// The first result of a character appears once it has passed the queue, the
// sequencer's load state and the output register. The sequencer loads a
// character in a state that gives no result and then gives one result per
// cycle while out_stall_i is low. A small queue in front takes characters
// while the sequencer works. When out_stall_i is high the output register
// holds and the sequencer waits; in_stall_o rises once the queue is full.
// Reset clears the queue and the sequencer and loads the register defaults
// (100000 ticks per unit, dash of 5 units, character gap on).
module morse_character_keyer #(
  parameter int FifoDepth = mkey_pkg::FIFO_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mkey_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mkey_pkg::UNIT_TICKS_W-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mkey_pkg::CHAR_W-1:0]         character_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                key_down_o,
  output logic [mkey_pkg::DUR_W-1:0]          duration_ticks_o,
  output logic                                last_o
);
  import mkey_pkg::*;

  cfg_t   cfg_q;
  entry_t push_entry, pop_entry;
  logic   q_push, q_pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_ticks <= RST_UNIT_TICKS;
      cfg_q.dash_units <= RST_DASH_UNITS;
      cfg_q.gap_enable <= RST_GAP_ENABLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UNIT_TICKS: cfg_q.unit_ticks <= cfg_data_i;
        CFG_DASH_UNITS: cfg_q.dash_units <= cfg_data_i[DASH_W-1:0];
        CFG_GAP_ENABLE: cfg_q.gap_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mkey_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  mkey_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (pop_entry),
    .empty_o (q_empty)
  );

  mkey_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .q_entry_i        (pop_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_down_o       (key_down_o),
    .duration_ticks_o (duration_ticks_o),
    .last_o           (last_o)
  );

endmodule

>>> rtl/mkey_checker.sv
module mkey_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        key_down_o,
  input logic [24:0] duration_ticks_o,
  input logic        last_o
);

  logic       in_acc, out_acc;
  logic [3:0] pending_q;
  logic       prev_tone_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // characters accepted whose final result is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      prev_tone_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {3'd0, in_acc} - {3'd0, out_acc && last_o};
      if (out_acc) begin
        prev_tone_q <= key_down_o && !last_o;
      end
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_down_o)
      && $stable(duration_ticks_o) && $stable(last_o))
    else $error("stalled result changed");

  // no result without a character in flight
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("result without an accepted character");

  // an idle block never stalls its input
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 4'd0 |-> !in_stall_o)
    else $error("input stalled while idle");

  // a tone inside a character is always followed by a silence
  a_tone_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prev_tone_q |-> !key_down_o)
    else $error("two tones without a gap");

endmodule

bind morse_character_keyer mkey_checker u_mkey_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .key_down_o       (key_down_o),
  .duration_ticks_o (duration_ticks_o),
  .last_o           (last_o)
);
